[sv/window_variance_settle_detector_macros.svh]
// Assertion macros shared by the window variance settle detector RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef WINDOW_VARIANCE_SETTLE_DETECTOR_MACROS_SVH
`define WINDOW_VARIANCE_SETTLE_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define WVSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wvsd_pkg.sv]
// Package for the window variance settle detector: result layout, register map
// and output saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wvsd_pkg;

    localparam int THRESH_W     = 25;
    localparam int SPREAD_OUT_W = 25;
    localparam int SUM_OUT_W    = 14;
    localparam int PEAK_OUT_W   = 10;
    localparam int OUT_TDATA_W  = 56;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 25'd20;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register word index within paddr
    localparam logic [APB_ADDR_W-3:0] REG_SPREAD_THRESHOLD = 1'b0;

    localparam logic [63:0] SPREAD_MAX = (64'd1 << SPREAD_OUT_W) - 64'd1;
    localparam logic [63:0] SUM_MAX    = (64'd1 << SUM_OUT_W) - 64'd1;
    localparam logic [63:0] PEAK_MAX   = (64'd1 << PEAK_OUT_W) - 64'd1;

    // packed lowest field last
    typedef struct packed {
        logic [PEAK_OUT_W-1:0]   peak_sample;
        logic [SUM_OUT_W-1:0]    window_sum;
        logic [SPREAD_OUT_W-1:0] spread;
        logic                    window_full;
        logic                    settled;
    } t_result;

    function automatic logic [63:0] sat64(input logic [63:0] v, input logic [63:0] max_v);
        return (v > max_v) ? max_v : v;
    endfunction

endpackage

`default_nettype wire

[sv/window_variance_settle_detector.sv]
// Window variance settle detector: top level with the sample pipeline,
// running window statistics and APB threshold register. Uses wvsd_pkg and the macros header.
// A result leaves from the result register after its sample has passed the input and square
// stages; one sample per cycle is sustained while m_axis_tready keeps the output moving. Each
// sample is squared in a stage of its own, then the result stage adds it to the running sum
// and sum of squares, drops the oldest sample of the shift-line window and computes
// WINDOW_LEN*sum_sq - sum^2 for the settle test. Once settled the statistics freeze until
// reset. Input ready follows the per-stage enables: while a result waits, up to two more
// samples enter, then the input stalls with the output. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module window_variance_settle_detector #(
    parameter int WINDOW_LEN  = 10,
    parameter int SAMPLE_BITS = 10
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // stream in
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: sample, override
    input  wire  [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] s_axis_tdata,
    // stream out
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata: settled, window_full, spread, window_sum, peak_sample
    output logic [wvsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // APB configuration
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [wvsd_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire  [wvsd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wvsd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

`include "window_variance_settle_detector_macros.svh"

    localparam longint unsigned SMAX = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam int SUM_W   = $clog2(WINDOW_LEN * SMAX + 1);
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int SQSUM_W = $clog2(WINDOW_LEN * SMAX * SMAX + 1);
    localparam int PROD_W  = $clog2(WINDOW_LEN * WINDOW_LEN * SMAX * SMAX + 1);
    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int CMP_W   = (PROD_W > wvsd_pkg::THRESH_W) ? PROD_W : wvsd_pkg::THRESH_W;

    // stage enables
    logic en_out;
    logic en_b;
    logic en_a;
    logic upd;

    // input stage
    logic                   r_a_valid;
    logic [SAMPLE_BITS-1:0] r_a_sample;
    logic                   r_a_ovr;

    // square stage
    logic                   r_b_valid;
    logic [SAMPLE_BITS-1:0] r_b_sample;
    logic [SQ_W-1:0]        r_b_sq;
    logic                   r_b_ovr;

    // window state, also the result register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_ring_s  [WINDOW_LEN];
    logic [SQ_W-1:0]        r_ring_sq [WINDOW_LEN];
    logic [FILL_W-1:0]      r_fill;
    logic [SUM_W-1:0]       r_sum;
    logic [SQSUM_W-1:0]     r_sqsum;
    logic [PROD_W-1:0]      r_spread;
    logic [SAMPLE_BITS-1:0] r_peak;
    logic                   r_settled;

    logic [wvsd_pkg::THRESH_W-1:0] r_thresh;

    // next values
    logic                   full;
    logic                   n_full;
    logic [SUM_W:0]         sum_add;
    logic [SUM_W-1:0]       n_sum;
    logic [SQSUM_W:0]       sq_add;
    logic [SQSUM_W-1:0]     n_sqsum;
    logic [FILL_W-1:0]      n_fill;
    logic [SAMPLE_BITS-1:0] n_peak;
    logic [PROD_W-1:0]      prod_a;
    logic [2*SUM_W-1:0]     prod_b;
    logic [PROD_W-1:0]      spread_raw;
    logic [PROD_W-1:0]      n_spread;
    logic                   n_settled;
    logic                   cfg_wr;

    wvsd_pkg::t_result result;

    assign en_out        = !r_out_valid || m_axis_tready;
    assign en_b          = !r_b_valid || en_out;
    assign en_a          = !r_a_valid || en_b;
    assign s_axis_tready = en_a;
    assign upd           = r_b_valid && en_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && s_axis_tvalid) begin
            r_a_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_a_ovr    <= s_axis_tdata[SAMPLE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_valid) begin
            r_b_sample <= r_a_sample;
            r_b_sq     <= r_a_sample * r_a_sample;
            r_b_ovr    <= r_a_ovr;
        end
    end

    // window update
    always_comb begin
        full    = (r_fill == FILL_W'(WINDOW_LEN));
        n_full  = full || (r_fill == FILL_W'(WINDOW_LEN - 1));
        n_fill  = full ? r_fill : r_fill + FILL_W'(1);
        n_peak  = (r_b_sample > r_peak) ? r_b_sample : r_peak;

        sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_b_sample);
        if (full) begin
            sum_add = sum_add - (SUM_W + 1)'(r_ring_s[WINDOW_LEN-1]);
        end
        n_sum   = sum_add[SUM_W-1:0];

        sq_add  = {1'b0, r_sqsum} + (SQSUM_W + 1)'(r_b_sq);
        if (full) begin
            sq_add = sq_add - (SQSUM_W + 1)'(r_ring_sq[WINDOW_LEN-1]);
        end
        n_sqsum = sq_add[SQSUM_W-1:0];

        prod_a     = PROD_W'(n_sqsum) * PROD_W'(WINDOW_LEN);
        prod_b     = n_sum * n_sum;
        spread_raw = (prod_a > PROD_W'(prod_b)) ? prod_a - PROD_W'(prod_b) : '0;
        n_spread   = n_full ? spread_raw : '0;

        n_settled  = r_b_ovr
                  || (n_full && (CMP_W'(n_spread) < CMP_W'(r_thresh)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_sum     <= '0;
            r_sqsum   <= '0;
            r_spread  <= '0;
            r_peak    <= '0;
            r_settled <= 1'b0;
        end else if (upd && !r_settled) begin
            r_fill    <= n_fill;
            r_sum     <= n_sum;
            r_sqsum   <= n_sqsum;
            r_spread  <= n_spread;
            r_peak    <= n_peak;
            r_settled <= n_settled;
        end
    end

    // oldest sample sits at the far end of the shift line
    always_ff @(posedge i_clk) begin
        if (upd && !r_settled) begin
            r_ring_s[0]  <= r_b_sample;
            r_ring_sq[0] <= r_b_sq;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                r_ring_s[i]  <= r_ring_s[i-1];
                r_ring_sq[i] <= r_ring_sq[i-1];
            end
        end
    end

    always_comb begin
        result.settled     = r_settled;
        result.window_full = (r_fill == FILL_W'(WINDOW_LEN));
        result.spread      = wvsd_pkg::SPREAD_OUT_W'(
            wvsd_pkg::sat64(64'(r_spread), wvsd_pkg::SPREAD_MAX));
        result.window_sum  = wvsd_pkg::SUM_OUT_W'(
            wvsd_pkg::sat64(64'(r_sum), wvsd_pkg::SUM_MAX));
        result.peak_sample = wvsd_pkg::PEAK_OUT_W'(
            wvsd_pkg::sat64(64'(r_peak), wvsd_pkg::PEAK_MAX));
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = wvsd_pkg::OUT_TDATA_W'(result);

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[wvsd_pkg::APB_ADDR_W-1:2] == wvsd_pkg::REG_SPREAD_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= wvsd_pkg::THRESH_RESET;
        end else if (cfg_wr) begin
            r_thresh <= pwdata[wvsd_pkg::THRESH_W-1:0];
        end
    end

    always_comb begin
        if (paddr[wvsd_pkg::APB_ADDR_W-1:2] == wvsd_pkg::REG_SPREAD_THRESHOLD) begin
            prdata = wvsd_pkg::APB_DATA_W'(r_thresh);
        end else begin
            prdata = '0;
        end
    end

    `WVSD_ASSERT_NEXT(a_settled_sticky, i_clk, i_rst_n, r_settled, r_settled,
        "settled flag dropped without reset")
    `WVSD_ASSERT_NEXT(a_frozen_after_settle, i_clk, i_rst_n, r_settled,
        $stable(r_sum) && $stable(r_sqsum) && $stable(r_peak) && $stable(r_spread),
        "window statistics changed after settling")
    `WVSD_ASSERT_SAME(a_spread_zero_unfilled, i_clk, i_rst_n,
        r_fill != FILL_W'(WINDOW_LEN), r_spread == '0,
        "spread non-zero before window full")
    `WVSD_ASSERT_SAME(a_fill_bounded, i_clk, i_rst_n, 1'b1,
        r_fill <= FILL_W'(WINDOW_LEN),
        "fill count beyond window length")

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for window_variance_settle_detector: samples stream in with random
// bursts and output stalls, each result is checked against a local window statistics model.
// Depends on wvsd_pkg and the detector RTL.
module tb_top;

    localparam int         WIN_LEN       = 10;
    localparam int         IN_W          = 16;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         RANDOM_ITEMS  = 560;
    localparam int         GUARD_CEILING = 2_000_000;
    localparam logic [9:0] RAIL_HI       = 10'd1023;
    localparam logic [9:0] RAIL_LO       = 10'd0;
    localparam logic [wvsd_pkg::APB_ADDR_W-1:0] THRESH_ADDR =
        {wvsd_pkg::REG_SPREAD_THRESHOLD, 2'b00};
    localparam logic [wvsd_pkg::THRESH_W-1:0]   THRESH_TOP  = '1;

    typedef enum int {SRC_UNIFORM, SRC_NARROW, SRC_DECAY, SRC_RAILS} t_source;
    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PULSED} t_stall;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata;   // sample[9:0], override[10], zero fill
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // settled, window_full, spread, window_sum, peak
    logic [wvsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [wvsd_pkg::APB_ADDR_W-1:0] paddr;
    logic [wvsd_pkg::APB_DATA_W-1:0] pwdata;
    logic [wvsd_pkg::APB_DATA_W-1:0] prdata;
    logic                  pready;

    // local model of the window statistics
    logic [9:0]          win_ring [WIN_LEN];
    int unsigned         win_slot;
    int unsigned         win_fill;
    longint              win_sum;
    longint              win_sq_sum;
    logic [9:0]          win_peak;
    bit                  win_settled;
    logic [wvsd_pkg::THRESH_W-1:0] win_thresh;

    wvsd_pkg::t_result expected_results[$];
    int      error_count     = 0;
    int      samples_sent    = 0;
    int      results_checked = 0;
    int      thresh_writes   = 0;
    int      burst_left      = 0;
    int      idle_cycles     = 0;
    string   settle_route    = "none";

    window_variance_settle_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint window_spread();
        longint a;
        longint b;
        if (win_fill < WIN_LEN) return 0;
        a = WIN_LEN * win_sq_sum;
        b = win_sum * win_sum;
        return (a > b) ? a - b : 0;
    endfunction

    // spread the full window would have if s replaced the oldest sample
    function automatic longint spread_if_taken(input logic [9:0] s);
        longint sv;
        longint old_v;
        longint sum_n;
        longint sq_n;
        longint a;
        sv    = longint'(s);
        old_v = longint'(win_ring[win_slot]);
        sum_n = win_sum - old_v + sv;
        sq_n  = win_sq_sum - old_v * old_v + sv * sv;
        a     = WIN_LEN * sq_n;
        return (a > sum_n * sum_n) ? a - sum_n * sum_n : 0;
    endfunction

    function automatic wvsd_pkg::t_result advance_window(input logic [9:0] s, input bit ovr);
        wvsd_pkg::t_result r;
        longint  sv;
        longint  old_v;
        sv = longint'(s);
        if (!win_settled) begin
            if (s > win_peak) win_peak = s;
            if (win_fill >= WIN_LEN) begin
                old_v = longint'(win_ring[win_slot]);
                win_sum    -= old_v;
                win_sq_sum -= old_v * old_v;
            end else begin
                win_fill++;
            end
            win_ring[win_slot] = s;
            win_sum    += sv;
            win_sq_sum += sv * sv;
            win_slot = (win_slot + 1 >= WIN_LEN) ? 0 : win_slot + 1;
            if (win_fill >= WIN_LEN && window_spread() < longint'(win_thresh)) win_settled = 1'b1;
            if (ovr) win_settled = 1'b1;
        end
        r.settled     = win_settled;
        r.window_full = (win_fill >= WIN_LEN);
        r.spread      = wvsd_pkg::SPREAD_OUT_W'(window_spread());
        r.window_sum  = wvsd_pkg::SUM_OUT_W'(win_sum);
        r.peak_sample = win_peak;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic push_sample(input logic [9:0] s, input bit ovr);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(12, 1);
            burst_left = $urandom_range(40, 1);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {{(IN_W - 11){1'b0}}, ovr, s};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(advance_window(s, ovr));
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [wvsd_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESH_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        win_thresh = value[wvsd_pkg::THRESH_W-1:0];
        thresh_writes++;
    endtask

    task automatic check_threshold_read(input logic [wvsd_pkg::APB_DATA_W-1:0] want);
        logic [wvsd_pkg::APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESH_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $error("prdata: expected %0d, got %0d", want, got);
            error_count++;
        end
    endtask

    task automatic test_register_access();
        check_threshold_read(wvsd_pkg::APB_DATA_W'(wvsd_pkg::THRESH_RESET));
        set_threshold('1);
        check_threshold_read(wvsd_pkg::APB_DATA_W'(THRESH_TOP));
    endtask

    // largest threshold while filling: no spread test until the window is full
    task automatic test_window_fill();
        for (int i = 0; i < WIN_LEN - 1; i++) push_sample(i[0] ? RAIL_HI : RAIL_LO, 1'b0);
        wait_drained();
        set_threshold('0);
        check_threshold_read('0);
    endtask

    // zero threshold: neither the widest nor a flat window may settle
    task automatic test_rail_windows();
        push_sample(RAIL_HI, 1'b0);
        for (int i = 0; i < WIN_LEN; i++) push_sample(RAIL_HI, 1'b0);
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          run_len;
        int          amp;
        int          v;
        t_source     src;
        logic [9:0]  base;
        logic [9:0]  s;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(3, 0))
                0:       set_threshold('0);
                1:       set_threshold($urandom_range(64, 1));
                default: set_threshold($urandom_range(GUARD_CEILING, 65));
            endcase
            src     = t_source'($urandom_range(3, 0));
            run_len = $urandom_range(80, 30);
            base    = 10'($urandom_range(1016, 0));
            amp     = 512;
            for (int n = 0; n < run_len; n++) begin
                case (src)
                    SRC_UNIFORM: s = 10'($urandom_range(1023, 0));
                    SRC_NARROW:  s = base + 10'($urandom_range(7, 0));
                    SRC_DECAY: begin
                        if (n % 8 == 7) amp = amp / 2;
                        v = int'(base) + $urandom_range(2 * amp, 0) - amp;
                        s = (v < 0) ? RAIL_LO : (v > 1023) ? RAIL_HI : v[9:0];
                    end
                    default:     s = $urandom_range(1, 0) ? RAIL_HI : RAIL_LO;
                endcase
                // keep this phase unsettled: a far outlier lifts spread above the ceiling
                if (spread_if_taken(s) < longint'(win_thresh))
                    s = (spread_if_taken(RAIL_LO) > spread_if_taken(RAIL_HI)) ? RAIL_LO : RAIL_HI;
                push_sample(s, 1'b0);
            end
            sent += run_len;
        end
    endtask

    // threshold equal to spread must hold off; then settle by the test or by override
    task automatic test_settle();
        longint held;
        wait_drained();
        held = window_spread();
        set_threshold(wvsd_pkg::APB_DATA_W'(held));
        push_sample(win_ring[win_slot], 1'b0);
        if ($urandom_range(1, 0) == 1) begin
            settle_route = "override";
            push_sample(win_ring[win_slot], 1'b1);
        end else begin
            settle_route = "spread below threshold";
            wait_drained();
            set_threshold(wvsd_pkg::APB_DATA_W'(held + 1));
            push_sample(win_ring[win_slot], 1'b0);
        end
        for (int i = 0; i < 24; i++)
            push_sample(10'($urandom_range(1023, 0)), 1'($urandom_range(1, 0)));
    endtask

    initial begin
        t_stall mode;
        int     mode_left;
        m_axis_tready <= 1'b0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_stall'($urandom_range(3, 0));
                mode_left = $urandom_range(150, 30);
            end
            mode_left--;
            case (mode)
                READY_ALWAYS: m_axis_tready <= 1'b1;
                READY_MOSTLY: m_axis_tready <= ($urandom_range(3, 0) != 0);
                READY_RARELY: m_axis_tready <= ($urandom_range(3, 0) == 0);
                default:      m_axis_tready <= mode_left[2];
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        wvsd_pkg::t_result got;
        wvsd_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = wvsd_pkg::t_result'(m_axis_tdata[$bits(wvsd_pkg::t_result)-1:0]);
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing pending: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                compare_field("settled", 32'(want.settled), 32'(got.settled));
                compare_field("window_full", 32'(want.window_full), 32'(got.window_full));
                compare_field("spread", 32'(want.spread), 32'(got.spread));
                compare_field("window_sum", 32'(want.window_sum), 32'(got.window_sum));
                compare_field("peak_sample", 32'(want.peak_sample), 32'(got.peak_sample));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("** window_variance_settle_detector: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        foreach (win_ring[i]) win_ring[i] = '0;
        win_slot    = 0;
        win_fill    = 0;
        win_sum     = 0;
        win_sq_sum  = 0;
        win_peak    = '0;
        win_settled = 1'b0;
        win_thresh  = wvsd_pkg::THRESH_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_window_fill();
        test_rail_windows();
        test_random_traffic();
        test_settle();
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("%0d samples sent, %0d results compared, %0d threshold writes incl. 0 and max",
                 samples_sent, results_checked, thresh_writes);
        $display("settled via %s after the equal-threshold hold-off", settle_route);
        if (error_count == 0) begin
            $display("** window_variance_settle_detector: PASSED **");
        end else begin
            $display("** window_variance_settle_detector: FAILED **");
        end
        $finish;
    end

endmodule

[window_variance_settle_detector.f]
+incdir+sv
sv/wvsd_pkg.sv
sv/window_variance_settle_detector.sv
sim/tb_top.sv
